### sv/ptdt_pkg.sv
`default_nettype none

package ptdt_pkg;

   localparam int TaskIdWidth = 5;
   localparam int TickWidth   = 32;

   // Request modes.
   localparam logic [1:0] MODE_TIME = 2'd0;
   localparam logic [1:0] MODE_REL  = 2'd1;
   localparam logic [1:0] MODE_ABS  = 2'd2;
   localparam logic [1:0] MODE_TICK = 2'd3;

   // Reply codes.
   localparam logic [1:0] RC_TIME = 2'd0;
   localparam logic [1:0] RC_DONE = 2'd1;
   localparam logic [1:0] RC_NEG  = 2'd2;
   localparam logic [1:0] RC_TICK = 2'd3;

   typedef struct packed {
      logic [1:0]             mode;
      logic [TaskIdWidth-1:0] task_id;
      logic [TickWidth-1:0]   amount;
   } req_type;

   typedef struct packed {
      logic [TaskIdWidth-1:0] dest_task;
      logic [1:0]             reply_code;
      logic [TickWidth-1:0]   now_ticks;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic [TickWidth-1:0] a;
      logic [TickWidth-1:0] b;
      logic                 cin;
   } alu_in_type;

endpackage

`default_nettype wire

### sv/ptdt_ram.sv
`default_nettype none

module ptdt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire  [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire  [WIDTH-1:0]          wr_data,
   input  wire  [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### sv/ptdt_alu.sv
`default_nettype none

module ptdt_alu
   import ptdt_pkg::*;
(
   input  wire alu_in_type             alu_in,
   output logic [TickWidth-1:0]        sum
);

   // Subtraction is done by the caller passing the inverted operand and a carry in.
   assign sum = alu_in.a + alu_in.b + {{(TickWidth-1){1'b0}}, alu_in.cin};

endmodule

`default_nettype wire

### sv/per_task_delay_timer_table_top.sv
`default_nettype none

// Channel   Ports                           Moves
// req       req_valid, req_ready, req_data  one request: mode, task_id, amount
// rsp       rsp_valid, rsp_ready, rsp_data  one reply: dest_task, reply_code, now_ticks, last
//
// A time query or delay runs in the execute state and returns to idle. A tick runs the
// execute, sweep and flush states; the slot table is swept one slot per cycle (held while
// an expiry waits on the reply register) through the single adder and the one read port
// of the slot memory. Reset clears the tick count and the per-slot valid bits; no
// clearing pass is needed. A waiting reply stalls the sweep only when a slot expires;
// a new request is taken while the last reply of the previous one still waits.

module per_task_delay_timer_table_top
   import ptdt_pkg::*;
#(
   parameter int NUM_TASKS = 32
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(NUM_TASKS);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_SWEEP = 5'b00100,
      S_FLUSH = 5'b01000,
      S_SPARE = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   req_type                req_ff, req_in;
   logic [TickWidth-1:0]   count_ff, count_in;
   rsp_type                hold_ff, hold_in;
   logic                   hold_valid_ff, hold_valid_in;
   rsp_type                rsp_ff;
   logic                   rsp_valid_ff;
   logic [AW-1:0]          rd_addr_ff, rd_addr_in;
   logic [NUM_TASKS-1:0]   valid_ff, valid_in;

   logic                   out_free;
   logic                   out_load;
   rsp_type                out_data;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [TickWidth-1:0]   wr_data;
   logic [AW-1:0]          rd_addr;
   logic [TickWidth-1:0]   rd_data;
   logic [TickWidth-1:0]   slot_val;
   alu_in_type             alu_in;
   logic [TickWidth-1:0]   alu_sum;
   logic                   slot_in_range;
   logic                   done_hit;

   ptdt_ram #(
      .WIDTH(TickWidth),
      .DEPTH(NUM_TASKS)
   ) u_slots (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   ptdt_alu u_alu (
      .alu_in(alu_in),
      .sum   (alu_sum)
   );

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign slot_in_range = int'(req_ff.task_id) < NUM_TASKS;
   // A slot that was never written since reset reads as idle.
   assign slot_val      = valid_ff[rd_addr_ff] ? rd_data : '0;
   assign done_hit      = (slot_val != '0) && (alu_sum == '0);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rd_addr_in    = rd_addr_ff;
      valid_in      = valid_ff;
      out_load      = 1'b0;
      out_data      = '0;
      wr_en         = 1'b0;
      wr_addr       = AW'(req_ff.task_id);
      wr_data       = req_ff.amount;
      rd_addr       = rd_addr_ff;
      alu_in        = '{a: count_ff, b: TickWidth'(1), cin: 1'b0};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rd_addr    = '0;
            rd_addr_in = '0;
            unique case (req_ff.mode)
               MODE_TIME: begin
                  if (out_free) begin
                     out_load = 1'b1;
                     out_data = '{dest_task: req_ff.task_id, reply_code: RC_TIME,
                                  now_ticks: count_ff, last: 1'b1};
                     state_in = S_IDLE;
                  end
               end
               MODE_REL: begin
                  if (req_ff.amount != '0) begin
                     if (slot_in_range) begin
                        wr_en             = 1'b1;
                        valid_in[wr_addr] = 1'b1;
                     end
                     state_in = S_IDLE;
                  end else if (out_free) begin
                     out_load = 1'b1;
                     out_data = '{dest_task: req_ff.task_id, reply_code: RC_DONE,
                                  now_ticks: count_ff, last: 1'b1};
                     state_in = S_IDLE;
                  end
               end
               MODE_ABS: begin
                  alu_in = '{a: req_ff.amount, b: ~count_ff, cin: 1'b1};
                  if (alu_sum == '0) begin
                     if (out_free) begin
                        out_load = 1'b1;
                        out_data = '{dest_task: req_ff.task_id, reply_code: RC_DONE,
                                     now_ticks: count_ff, last: 1'b1};
                        state_in = S_IDLE;
                     end
                  end else if (alu_sum[TickWidth-1]) begin
                     if (out_free) begin
                        out_load = 1'b1;
                        out_data = '{dest_task: req_ff.task_id, reply_code: RC_NEG,
                                     now_ticks: '0, last: 1'b1};
                        state_in = S_IDLE;
                     end
                  end else begin
                     wr_data = alu_sum;
                     if (slot_in_range) begin
                        wr_en             = 1'b1;
                        valid_in[wr_addr] = 1'b1;
                     end
                     state_in = S_IDLE;
                  end
               end
               MODE_TICK: begin
                  count_in      = alu_sum;
                  hold_in       = '{dest_task: req_ff.task_id, reply_code: RC_TICK,
                                    now_ticks: '0, last: 1'b0};
                  hold_valid_in = 1'b1;
                  state_in      = S_SWEEP;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SWEEP: begin
            // The held reply goes out only once a later one is known, so that
            // the final reply of the tick can carry the last flag.
            alu_in = '{a: slot_val, b: '1, cin: 1'b0};
            if (!(done_hit && !out_free)) begin
               if (slot_val != '0) begin
                  wr_en   = 1'b1;
                  wr_addr = rd_addr_ff;
                  wr_data = alu_sum;
               end
               if (done_hit) begin
                  out_load = 1'b1;
                  out_data = hold_ff;
                  hold_in  = '{dest_task: TaskIdWidth'(rd_addr_ff), reply_code: RC_DONE,
                               now_ticks: count_ff, last: 1'b0};
               end
               if (rd_addr_ff == AW'(NUM_TASKS - 1)) begin
                  state_in = S_FLUSH;
               end else begin
                  rd_addr    = rd_addr_ff + AW'(1);
                  rd_addr_in = rd_addr;
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_data      = hold_ff;
               out_data.last = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         valid_ff      <= '0;
         rd_addr_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         hold_valid_ff <= hold_valid_in;
         valid_ff      <= valid_in;
         rd_addr_ff    <= rd_addr_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      hold_ff <= hold_in;
      if (out_load) begin
         rsp_ff <= out_data;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_idle_no_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !hold_valid_ff)
      else $error("held reply left over while idle");

   a_sweep_has_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP || state_ff == S_FLUSH) |-> hold_valid_ff)
      else $error("sweep running without a held reply");

   a_tick_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && req_ff.mode == MODE_TICK)
      |=> (count_ff == $past(count_ff) + TickWidth'(1)))
      else $error("tick did not advance the count by one");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("reply register overwritten while occupied");
`endif

endmodule

`default_nettype wire

### dv/ptdt_reply_checker.sv
module ptdt_reply_checker
   import ptdt_pkg::*;
#(
   parameter int NUM_TASKS = 32
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   input  wire          req_ready,
   input  wire req_type req_data,
   input  wire          rsp_valid,
   input  wire          rsp_ready,
   input  wire rsp_type rsp_data,
   output int           mismatch_count,
   output int           replies_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [TickWidth-1:0] tick_now;
   logic [TickWidth-1:0] countdown [NUM_TASKS];
   rsp_type              expected_replies [$];
   rsp_type              reply_batch [$];
   rsp_type              want;

   task automatic add_reply(input int dest, input logic [1:0] code,
                            input logic [TickWidth-1:0] now);
      rsp_type r;
      r.dest_task  = TaskIdWidth'(dest);
      r.reply_code = code;
      r.now_ticks  = now;
      r.last       = 1'b0;
      reply_batch.push_back(r);
   endtask

   // Works out the replies one request causes and updates the timer table.
   task automatic apply_request(input req_type rq);
      logic [TickWidth-1:0] diff;
      rsp_type              tail;
      reply_batch.delete();
      case (rq.mode)
         MODE_TIME: begin
            add_reply(rq.task_id, RC_TIME, tick_now);
         end
         MODE_REL: begin
            if (rq.amount != '0) begin
               if (rq.task_id < NUM_TASKS) countdown[rq.task_id] = rq.amount;
            end else begin
               add_reply(rq.task_id, RC_DONE, tick_now);
            end
         end
         MODE_ABS: begin
            diff = rq.amount - tick_now;
            if (diff == '0) begin
               add_reply(rq.task_id, RC_DONE, tick_now);
            end else if (diff[TickWidth-1]) begin
               add_reply(rq.task_id, RC_NEG, '0);
            end else if (rq.task_id < NUM_TASKS) begin
               countdown[rq.task_id] = diff;
            end
         end
         default: begin
            tick_now = tick_now + 1'b1;
            add_reply(rq.task_id, RC_TICK, '0);
            // Slots are released in ascending order after the tick acknowledgement.
            for (int i = 0; i < NUM_TASKS; i++) begin
               if (countdown[i] != '0) begin
                  countdown[i] = countdown[i] - 1'b1;
                  if (countdown[i] == '0) add_reply(i, RC_DONE, tick_now);
               end
            end
         end
      endcase
      if (reply_batch.size() != 0) begin
         tail      = reply_batch.pop_back();
         tail.last = 1'b1;
         reply_batch.push_back(tail);
      end
      foreach (reply_batch[k]) expected_replies.push_back(reply_batch[k]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tick_now = '0;
         foreach (countdown[i]) countdown[i] = '0;
         expected_replies.delete();
         mismatch_count = 0;
      end else begin
         if (req_valid && req_ready) apply_request(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               $error("unexpected reply: dest_task %0d reply_code %0d now_ticks %0d",
                      rsp_data.dest_task, rsp_data.reply_code, rsp_data.now_ticks);
               mismatch_count++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_data.dest_task !== want.dest_task) begin
                  $error("dest_task: expected %0d, actual %0d",
                         want.dest_task, rsp_data.dest_task);
                  mismatch_count++;
               end
               if (rsp_data.reply_code !== want.reply_code) begin
                  $error("reply_code: expected %0d, actual %0d",
                         want.reply_code, rsp_data.reply_code);
                  mismatch_count++;
               end
               if (rsp_data.now_ticks !== want.now_ticks) begin
                  $error("now_ticks: expected %0d, actual %0d",
                         want.now_ticks, rsp_data.now_ticks);
                  mismatch_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_data.last);
                  mismatch_count++;
               end
            end
         end
      end
      replies_pending = expected_replies.size();
   end

endmodule

### dv/tb_per_task_delay_timer_table_top.sv
module tb_per_task_delay_timer_table_top
   import ptdt_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_TASKS = 32;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_ready = 1'b0;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      mismatch_count;
   int      replies_pending;

   logic                 steady       = 1'b0;
   logic [TickWidth-1:0] ticks_sent   = '0;
   int                   requests_sent = 0;

   per_task_delay_timer_table_top #(
      .NUM_TASKS(NUM_TASKS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   ptdt_reply_checker #(
      .NUM_TASKS(NUM_TASKS)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .replies_pending(replies_pending)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 23);
   end

   function automatic req_type make_request(input logic [1:0] mode,
                                            input logic [TaskIdWidth-1:0] id,
                                            input logic [TickWidth-1:0] amount);
      req_type rq;
      rq.mode    = mode;
      rq.task_id = id;
      rq.amount  = amount;
      return rq;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic push_request(input req_type rq);
      while (!steady && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      if (rq.mode == MODE_TICK) ticks_sent++;
      @(negedge clock);
   endtask

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int                   kind;
      int                   offset;
      int                   span;
      int                   bursts_left;
      logic [TickWidth-1:0] target;
      bursts_left = 3;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_request(make_request(MODE_TIME, 5'd0, 32'hFFFF_FFFF));
      push_request(make_request(MODE_REL, 5'd31, '0));
      push_request(make_request(MODE_ABS, 5'd1, '0));
      push_request(make_request(MODE_ABS, 5'd2, 32'hFFFF_FFFF));
      push_request(make_request(MODE_ABS, 5'd3, 32'h8000_0000));
      push_request(make_request(MODE_ABS, 5'd4, 32'h7FFF_FFFF));
      push_request(make_request(MODE_REL, 5'd5, 32'hFFFF_FFFF));
      push_request(make_request(MODE_REL, 5'd6, 32'd2));
      push_request(make_request(MODE_REL, 5'd7, 32'd2));
      push_request(make_request(MODE_REL, 5'd0, 32'd1));
      push_request(make_request(MODE_ABS, 5'd31, 32'd2));
      // A zero delay and a negative target both reply and keep the pending slot.
      push_request(make_request(MODE_REL, 5'd6, '0));
      push_request(make_request(MODE_ABS, 5'd7, 32'hFFFF_FFF0));
      push_request(make_request(MODE_TICK, 5'd31, '0));
      // Overwrites the pending delay of task 6.
      push_request(make_request(MODE_REL, 5'd6, 32'd3));
      push_request(make_request(MODE_TICK, 5'd0, 32'hFFFF_FFFF));
      push_request(make_request(MODE_ABS, 5'd8, 32'd3));
      push_request(make_request(MODE_TIME, 5'd15, '0));
      push_request(make_request(MODE_TICK, 5'd16, '0));
      push_request(make_request(MODE_REL, 5'd4, 32'd1));
      push_request(make_request(MODE_ABS, 5'd5, 32'd5));
      push_request(make_request(MODE_TICK, 5'd5, '0));
      push_request(make_request(MODE_TICK, 5'd8, '0));

      while (requests_sent < 360) begin
         steady <= (requests_sent >= 200 && requests_sent < 270);
         kind = $urandom_range(99);
         if (kind < 30) begin
            push_request(make_request(MODE_TICK, TaskIdWidth'($urandom_range(NUM_TASKS - 1)),
                                      $urandom()));
         end else if (kind < 55) begin
            push_request(make_request(MODE_REL, TaskIdWidth'($urandom_range(NUM_TASKS - 1)),
                                      TickWidth'($urandom_range(6, 1))));
         end else if (kind < 70) begin
            // Targets close to the current count give past, present and future cases.
            offset = $urandom_range(9);
            target = ticks_sent + offset - 3;
            push_request(make_request(MODE_ABS, TaskIdWidth'($urandom_range(NUM_TASKS - 1)),
                                      target));
         end else if (kind < 78) begin
            push_request(make_request(MODE_TIME, TaskIdWidth'($urandom_range(NUM_TASKS - 1)),
                                      $urandom()));
         end else if (kind < 84) begin
            push_request(make_request(MODE_REL, TaskIdWidth'($urandom_range(NUM_TASKS - 1)),
                                      $urandom()));
         end else if (kind < 90) begin
            push_request(make_request(MODE_ABS, TaskIdWidth'($urandom_range(NUM_TASKS - 1)),
                                      $urandom()));
         end else if (kind < 93) begin
            push_request(make_request(MODE_REL, TaskIdWidth'($urandom_range(NUM_TASKS - 1)),
                                      '0));
         end else if (kind < 96 && bursts_left > 0) begin
            // Every slot expires on the same tick, giving the longest reply train.
            bursts_left--;
            span = $urandom_range(3, 1);
            for (int t = 0; t < NUM_TASKS; t++) begin
               push_request(make_request(MODE_REL, TaskIdWidth'(t), TickWidth'(span)));
            end
            repeat (span) begin
               push_request(make_request(MODE_TICK,
                                         TaskIdWidth'($urandom_range(NUM_TASKS - 1)),
                                         $urandom()));
            end
         end else begin
            push_request(make_request(MODE_TICK, TaskIdWidth'($urandom_range(NUM_TASKS - 1)),
                                      $urandom()));
         end
      end
      req_valid <= 1'b0;

      while (replies_pending != 0) @(negedge clock);
      repeat (NUM_TASKS + 8) @(negedge clock);
      if (mismatch_count == 0 && replies_pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
